[rtl/fpsl_pkg.sv]
// shared types and constants of the filtered pi speed loop
package fpsl_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam logic [8:0] ALPHA_ONE = 9'd256;

	typedef enum logic [2:0] {
		REG_SETPOINT  = 3'd0,
		REG_PROP_GAIN = 3'd1,
		REG_INTEG_GAIN = 3'd2,
		REG_ALPHA     = 3'd3,
		REG_LIMIT     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [16:0] speed_setpoint;
		logic signed [15:0] prop_gain;
		logic signed [15:0] integ_gain;
		logic [8:0]         filter_alpha;
		logic [15:0]        integral_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic filt_a;
		logic filt_b;
		logic integ;
		logic emit;
	} cmd_t;

endpackage

[rtl/fpsl_ctrl.sv]
// sequencing controller of the filtered pi speed loop
module fpsl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output fpsl_pkg::cmd_t cmd
);
	import fpsl_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FILT_A = 5'b00010,
		ST_FILT_B = 5'b00100,
		ST_INTEG  = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_FILT_A;
				end
			end
			ST_FILT_A: begin
				cmd.filt_a = 1'b1;
				state_d    = ST_FILT_B;
			end
			ST_FILT_B: begin
				cmd.filt_b = 1'b1;
				state_d    = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_cmd_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.filt_a)
		else $error("accepted beat did not start the filter step");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.emit)
		else $error("result overwritten while stalled");
`endif

endmodule

[rtl/fpsl_datapath.sv]
// shared-multiplier datapath: error, low-pass filter, clamped integral, pi output
module fpsl_datapath #(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpsl_pkg::cmd_t               cmd,
	input  fpsl_pkg::cfg_t               cfg,
	input  logic signed [COUNT_BITS-1:0] left_count,
	input  logic signed [COUNT_BITS-1:0] right_count,
	output logic signed [31:0]           drive_out
);
	import fpsl_pkg::*;

	localparam int EW  = ((COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17) + 1;
	localparam int FEW = EW + FRAC_BITS;
	localparam int IW  = 17 + FRAC_BITS;
	localparam int PW  = 17 + FEW;
	localparam int AW  = FEW + 18;
	localparam int RW  = AW - FRAC_BITS - 8;
	localparam int SW  = ((RW > 32) ? RW : 32) + 1;

	logic signed [EW-1:0]  err_q;
	logic signed [FEW-1:0] fe_q;
	logic signed [IW-1:0]  integ_q;
	logic signed [AW-1:0]  acc_q;
	logic signed [31:0]    out_q;

	logic [8:0]            alpha_c;
	logic [8:0]            alpha_inv;
	logic signed [16:0]    mul_a;
	logic signed [FEW-1:0] mul_b;
	logic signed [PW-1:0]  product;
	logic signed [AW-1:0]  prod_x;
	logic signed [AW-1:0]  filt_sum;
	logic signed [AW-1:0]  out_sum;
	logic signed [RW-1:0]  res;
	logic signed [SW-1:0]  res_x;
	logic signed [31:0]    res_sat;
	logic signed [FEW:0]   isum;
	logic signed [FEW:0]   lim_pos;
	logic signed [FEW:0]   lim_neg;
	logic signed [FEW:0]   isum_c;
	logic signed [EW-1:0]  err_d;

	assign alpha_c   = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
	assign alpha_inv = ALPHA_ONE - alpha_c;

	always_comb begin
		priority if (cmd.filt_a) begin
			mul_a = {8'd0, alpha_c};
			mul_b = {{FRAC_BITS{err_q[EW-1]}}, err_q};
		end else if (cmd.filt_b) begin
			mul_a = {8'd0, alpha_inv};
			mul_b = fe_q;
		end else if (cmd.integ) begin
			mul_a = {cfg.prop_gain[15], cfg.prop_gain};
			mul_b = fe_q;
		end else begin
			mul_a = {cfg.integ_gain[15], cfg.integ_gain};
			mul_b = {{(FEW-IW){integ_q[IW-1]}}, integ_q};
		end
	end

	assign product  = mul_a * mul_b;
	assign prod_x   = {{(AW-PW){product[PW-1]}}, product};
	assign filt_sum = acc_q + prod_x;
	assign out_sum  = acc_q + prod_x + (AW'(1) <<< (FRAC_BITS + 7));
	assign res      = out_sum[AW-1:FRAC_BITS+8];
	assign res_x    = {{(SW-RW){res[RW-1]}}, res};

	always_comb begin
		priority if (res_x > $signed({{(SW-32){1'b0}}, 32'h7fff_ffff})) begin
			res_sat = 32'sh7fff_ffff;
		end else if (res_x < $signed({{(SW-32){1'b1}}, 32'h8000_0000})) begin
			res_sat = 32'sh8000_0000;
		end else begin
			res_sat = res_x[31:0];
		end
	end

	assign isum    = {{(FEW+1-IW){integ_q[IW-1]}}, integ_q} + {fe_q[FEW-1], fe_q};
	assign lim_pos = {{(FEW+1-IW+1){1'b0}}, cfg.integral_limit, {FRAC_BITS{1'b0}}};
	assign lim_neg = -lim_pos;

	always_comb begin
		priority if (isum > lim_pos) begin
			isum_c = lim_pos;
		end else if (isum < lim_neg) begin
			isum_c = lim_neg;
		end else begin
			isum_c = isum;
		end
	end

	assign err_d = {{(EW-COUNT_BITS){left_count[COUNT_BITS-1]}}, left_count}
		+ {{(EW-COUNT_BITS){right_count[COUNT_BITS-1]}}, right_count}
		- {{(EW-17){cfg.speed_setpoint[16]}}, cfg.speed_setpoint};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q    <= '0;
			integ_q <= '0;
		end else begin
			if (cmd.filt_b) begin
				fe_q <= filt_sum[FEW+7:8];
			end
			if (cmd.integ) begin
				integ_q <= isum_c[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= err_d;
		end
		if (cmd.filt_a) begin
			acc_q <= (prod_x <<< FRAC_BITS) + AW'(128);
		end else if (cmd.integ) begin
			acc_q <= prod_x;
		end
		if (cmd.emit) begin
			out_q <= res_sat;
		end
	end

	assign drive_out = out_q;

`ifndef SYNTHESIS
	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.integ |=> ($signed({{(FEW+1-IW){integ_q[IW-1]}}, integ_q}) <= $past(lim_pos)
			&& $signed({{(FEW+1-IW){integ_q[IW-1]}}, integ_q}) >= $past(lim_neg)))
		else $error("integral outside clamp");
	a_fe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.filt_b |=> $stable(fe_q))
		else $error("filter state changed outside its step");
	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.integ |=> $stable(integ_q))
		else $error("integral changed outside its step");
`endif

endmodule

[rtl/filtered_pi_speed_loop_core.sv]
// a result beat is registered and offered after the filter, integral and output steps
// one beat at a time: the next is taken once the last has had its four shared-multiplier steps
// a stalled result holds the block in its output step until the beat is taken
// reset (arst_n low, asynchronous) clears filter and integral state, loads register defaults
// configuration writes take effect at once; no clearing pass after reset
// top level of the filtered pi speed loop with apb register port
module filtered_pi_speed_loop_core #(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// left_count, right_count
	input  logic [((2*COUNT_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// drive_out
	output logic [31:0]                          m_axis_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fpsl_pkg::ADDR_W-1:0]          paddr,
	input  logic [fpsl_pkg::DATA_W-1:0]          pwdata,
	output logic [fpsl_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);
	import fpsl_pkg::*;

	cfg_t               cfg_q;
	cmd_t               cmd;
	logic               wr_en;
	reg_idx_t           reg_idx;
	logic signed [31:0] drive_out;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_setpoint <= '0;
			cfg_q.prop_gain      <= '0;
			cfg_q.integ_gain     <= '0;
			cfg_q.filter_alpha   <= 9'd77;
			cfg_q.integral_limit <= 16'd10000;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SETPOINT:   cfg_q.speed_setpoint <= pwdata[16:0];
				REG_PROP_GAIN:  cfg_q.prop_gain      <= pwdata[15:0];
				REG_INTEG_GAIN: cfg_q.integ_gain     <= pwdata[15:0];
				REG_ALPHA:      cfg_q.filter_alpha   <= pwdata[8:0];
				REG_LIMIT:      cfg_q.integral_limit <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SETPOINT:   prdata = {{15{cfg_q.speed_setpoint[16]}}, cfg_q.speed_setpoint};
			REG_PROP_GAIN:  prdata = {{16{cfg_q.prop_gain[15]}}, cfg_q.prop_gain};
			REG_INTEG_GAIN: prdata = {{16{cfg_q.integ_gain[15]}}, cfg_q.integ_gain};
			REG_ALPHA:      prdata = {23'd0, cfg_q.filter_alpha};
			REG_LIMIT:      prdata = {16'd0, cfg_q.integral_limit};
			default:        prdata = '0;
		endcase
	end

	fpsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	fpsl_datapath #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.left_count  (s_axis_tdata[COUNT_BITS-1:0]),
		.right_count (s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS]),
		.drive_out   (drive_out)
	);

	assign m_axis_tdata = drive_out;

endmodule

[tb/tb.sv]
// self-checking testbench of the filtered pi speed loop core with a stream driver and monitor
`timescale 1ns / 1ps
module tb;
	import fpsl_pkg::*;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int HOLD_OFF = 8;

	typedef struct packed {
		logic signed [15:0] right;
		logic signed [15:0] left;
	} count_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// left_count, right_count
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// drive_out
	logic [31:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	filtered_pi_speed_loop_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	count_pair_t pair_q[$];
	logic [31:0] drive_q[$];

	longint setpoint = 0;
	longint kp = 0;
	longint ki = 0;
	longint alpha_w = 77;
	longint clamp_lim = 10000;
	longint filt_err = 0;
	longint integ_err = 0;

	int idle_pct = 38;
	bit in_took = 1'b0;
	int errors = 0;
	int mismatches = 0;
	int pairs_sent = 0;
	int drives_checked = 0;
	int settings_used = 0;

	function automatic logic [31:0] next_drive(input logic signed [15:0] l,
			input logic signed [15:0] r);
		longint err;
		longint a;
		longint lim;
		longint acc;
		longint res;
		err = longint'(l) + longint'(r) - setpoint;
		a = (alpha_w > 256) ? 256 : alpha_w;
		lim = clamp_lim * 256;
		filt_err = (a * (err * 256) + (256 - a) * filt_err + 128) >>> 8;
		integ_err = integ_err + filt_err;
		if (integ_err > lim)
			integ_err = lim;
		if (integ_err < -lim)
			integ_err = -lim;
		acc = kp * filt_err + ki * integ_err;
		res = (acc + 64'sd32768) >>> 16;
		if (res > 64'sd2147483647)
			res = 64'sd2147483647;
		if (res < -64'sd2147483648)
			res = -64'sd2147483648;
		return res[31:0];
	endfunction

	always @(posedge clk) begin
		in_took <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				drive_q.push_back(next_drive(s_axis_tdata[15:0], s_axis_tdata[31:16]));
				pairs_sent++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected drive_out beat %0d", $signed(m_axis_tdata));
				end else begin : check
					logic [31:0] want;
					want = drive_q.pop_front();
					drives_checked++;
					if (m_axis_tdata !== want) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display("drive_out mismatch at beat %0d: expected %0d got %0d",
								drives_checked, $signed(want), $signed(m_axis_tdata));
					end
				end
			end
		end
	end

	always @(negedge clk) begin : drive
		count_pair_t cur;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_took) begin
			if (pair_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				cur = pair_q.pop_front();
				s_axis_tdata <= cur;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= idle_pct);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SETPOINT: setpoint = longint'($signed(val[16:0]));
			REG_PROP_GAIN: kp = longint'($signed(val[15:0]));
			REG_INTEG_GAIN: ki = longint'($signed(val[15:0]));
			REG_ALPHA: alpha_w = longint'(val[8:0]);
			REG_LIMIT: clamp_lim = longint'(val[15:0]);
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_pair(input int l, input int r);
		count_pair_t p;
		p.left = 16'(l);
		p.right = 16'(r);
		pair_q.push_back(p);
	endtask

	task automatic settle();
		while (pair_q.size() != 0 || drive_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
		settings_used++;
	endtask

	task automatic shuffle_config();
		int pick;
		pick = $urandom_range(0, 3);
		write_reg(REG_SETPOINT, (pick == 0) ? $urandom : $urandom_range(0, 2000) - 1000);
		pick = $urandom_range(0, 3);
		write_reg(REG_PROP_GAIN, (pick == 0) ? $urandom_range(0, 1024) - 512 : $urandom);
		pick = $urandom_range(0, 3);
		write_reg(REG_INTEG_GAIN, (pick == 0) ? $urandom_range(0, 256) - 128 : $urandom);
		pick = $urandom_range(0, 9);
		case (pick)
			0: write_reg(REG_ALPHA, 0);
			1: write_reg(REG_ALPHA, ALPHA_ONE);
			2: write_reg(REG_ALPHA, $urandom_range(257, 511));
			default: write_reg(REG_ALPHA, $urandom_range(0, 256));
		endcase
		pick = $urandom_range(0, 4);
		case (pick)
			0: write_reg(REG_LIMIT, 0);
			1: write_reg(REG_LIMIT, 16'hffff);
			2: write_reg(REG_LIMIT, $urandom_range(0, 2000));
			default: write_reg(REG_LIMIT, $urandom);
		endcase
	endtask

	task automatic random_pairs(input int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 5)
				add_pair($urandom, $urandom);
			else if (sel < 9)
				add_pair(int'(setpoint / 2) + $urandom_range(0, 600) - 300,
					int'(setpoint / 2) + $urandom_range(0, 600) - 300);
			else
				add_pair(sel[0] ? 32767 : -32768, $urandom);
		end
	endtask

	initial begin
		#5_000_000;
		$display("filtered_pi_speed_loop_core test failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults, zero gains
		add_pair(1000, 2000);
		add_pair(-32768, 32767);
		add_pair(5, -7);
		settle();

		write_reg(REG_SETPOINT, 100);
		write_reg(REG_PROP_GAIN, 256);
		write_reg(REG_INTEG_GAIN, 64);
		add_pair(32767, 32767);
		add_pair(-32768, -32768);
		add_pair(32767, -32768);
		add_pair(0, 0);
		add_pair(-1, -1);
		add_pair(50, 50);
		add_pair(1, 0);
		settle();

		// unity filter with the integral held at zero
		write_reg(REG_ALPHA, ALPHA_ONE);
		write_reg(REG_LIMIT, 0);
		add_pair(12345, -300);
		add_pair(-20000, 100);
		add_pair(700, 700);
		settle();

		// weight above one acts as one, widest clamp
		write_reg(REG_ALPHA, 511);
		write_reg(REG_LIMIT, 16'hffff);
		add_pair(32767, 32767);
		add_pair(32767, 32767);
		add_pair(32767, 32767);
		settle();

		// filter frozen, then the clamp lowered under a large integral
		write_reg(REG_ALPHA, 0);
		add_pair(-32768, -32768);
		add_pair(0, 0);
		settle();
		write_reg(REG_LIMIT, 3);
		add_pair(0, 0);
		add_pair(100, 0);
		settle();

		// new register values, then writes to unused addresses that change nothing
		write_reg(REG_SETPOINT, 32'hffff_0000);
		write_reg(REG_PROP_GAIN, 32'h0000_8000);
		write_reg(REG_INTEG_GAIN, 32'h0000_7fff);
		write_reg(REG_ALPHA, 128);
		write_reg(REG_SPARE_LO, 32'hffff_ffff);
		write_reg(REG_SPARE_HI, 32'h1234_5678);
		add_pair(32767, 32767);
		add_pair(-32768, 32767);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			shuffle_config();
			idle_pct = (ph == 3) ? 0 : 38;
			random_pairs(140);
			settle();
		end
		idle_pct = 38;

		repeat (20) @(posedge clk);
		if (drive_q.size() != 0)
			errors++;
		$display("covered %0d input beats and %0d drive_out beats over %0d register settings",
			pairs_sent, drives_checked, settings_used);
		$display("including unity, frozen and over-range filter weights, clamp extremes");
		if (errors == 0)
			$display("filtered_pi_speed_loop_core test passed");
		else
			$display("filtered_pi_speed_loop_core test failed");
		$finish;
	end

endmodule
